>>> rtl/core/tac_pkg.sv
// shared constants and types for the tile average colour block
package tac_pkg;

   localparam int MAX_IMAGE_SIDE   = 4096;
   localparam int MAX_TILE         = 64;
   localparam int MAX_TILES_ACROSS = 2048;
   localparam int MIN_TILE         = 2;

   localparam int TSIZE_W    = 7;
   localparam int SIDE_W     = 13;
   localparam int POS_W      = 12;
   localparam int OFS_W      = 6;
   localparam int IDX_W      = 11;
   localparam int CHAN_W     = 8;
   localparam int SUM_W      = 20;
   localparam int COUNT_W    = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIDE_W;
   localparam int SUM_ADDR_W = $clog2(MAX_TILES_ACROSS);
   localparam int STEP_W     = $clog2(SUM_W);
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_TILE_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [TSIZE_W-1:0] TILE_SIZE_RESET    = 7'd8;
   localparam logic [SIDE_W-1:0]  IMAGE_WIDTH_RESET  = 13'd256;
   localparam logic [SIDE_W-1:0]  IMAGE_HEIGHT_RESET = 13'd256;

   typedef struct packed {
      logic [TSIZE_W-1:0] tile_size;
      logic [SIDE_W-1:0]  image_width;
      logic [SIDE_W-1:0]  image_height;
   } cfg_type;

   typedef struct packed {
      logic [SUM_ADDR_W-1:0] sum_addr;
      logic [IDX_W-1:0]      tile_column;
      logic [IDX_W-1:0]      tile_row;
      logic                  first_pixel;
      logic                  tile_done;
      logic                  image_done;
      logic [COUNT_W-1:0]    count;
   } pos_info_type;

   typedef struct packed {
      logic [SUM_W-1:0] blue;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] red;
   } sum_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIVIDE
   } state_type;

endpackage

>>> rtl/core/tac_sum_ram.sv
// band sum memory: one word of three channel sums per tile column
module tac_sum_ram (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [tac_pkg::SUM_ADDR_W-1:0] rd_addr,
   output tac_pkg::sum_word_type         rd_data,
   input  logic                          wr_en,
   input  logic [tac_pkg::SUM_ADDR_W-1:0] wr_addr,
   input  tac_pkg::sum_word_type         wr_data
);
   import tac_pkg::*;

   sum_word_type sum_mem [MAX_TILES_ACROSS];
   sum_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sum_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= sum_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tac_tracker.sv
// raster position, tile offsets and tile indices with end-of-tile flags
module tac_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  tac_pkg::cfg_type      cfg,
   input  logic                  advance,
   output tac_pkg::pos_info_type pos
);
   import tac_pkg::*;

   logic [POS_W-1:0] pix_col_ff, pix_col_in;
   logic [POS_W-1:0] pix_row_ff, pix_row_in;
   logic [OFS_W-1:0] ofs_x_ff, ofs_x_in;
   logic [OFS_W-1:0] ofs_y_ff, ofs_y_in;
   logic [IDX_W-1:0] tile_col_ff, tile_col_in;
   logic [IDX_W-1:0] tile_row_ff, tile_row_in;

   logic [TSIZE_W-1:0]   tile_side;
   logic [SIDE_W-1:0]    width_c;
   logic [SIDE_W-1:0]    height_c;
   logic                 row_end;
   logic                 col_end;
   logic                 tile_x_end;
   logic                 tile_y_end;
   logic [TSIZE_W-1:0]   span_x;
   logic [TSIZE_W-1:0]   span_y;
   logic [2*TSIZE_W-1:0] pix_count;

   always_comb begin
      priority if (cfg.tile_size < TSIZE_W'(MIN_TILE)) begin
         tile_side = TSIZE_W'(MIN_TILE);
      end else if (cfg.tile_size > TSIZE_W'(MAX_TILE)) begin
         tile_side = TSIZE_W'(MAX_TILE);
      end else begin
         tile_side = cfg.tile_size;
      end

      priority if (cfg.image_width == '0) begin
         width_c = SIDE_W'(1);
      end else if (cfg.image_width > SIDE_W'(MAX_IMAGE_SIDE)) begin
         width_c = SIDE_W'(MAX_IMAGE_SIDE);
      end else begin
         width_c = cfg.image_width;
      end

      priority if (cfg.image_height == '0) begin
         height_c = SIDE_W'(1);
      end else if (cfg.image_height > SIDE_W'(MAX_IMAGE_SIDE)) begin
         height_c = SIDE_W'(MAX_IMAGE_SIDE);
      end else begin
         height_c = cfg.image_height;
      end

      row_end    = {1'b0, pix_col_ff} >= (width_c - SIDE_W'(1));
      col_end    = {1'b0, pix_row_ff} >= (height_c - SIDE_W'(1));
      tile_x_end = row_end || ({1'b0, ofs_x_ff} >= (tile_side - TSIZE_W'(1)));
      tile_y_end = col_end || ({1'b0, ofs_y_ff} >= (tile_side - TSIZE_W'(1)));

      span_x    = {1'b0, ofs_x_ff} + TSIZE_W'(1);
      span_y    = {1'b0, ofs_y_ff} + TSIZE_W'(1);
      pix_count = span_x * span_y;

      pix_col_in  = pix_col_ff;
      pix_row_in  = pix_row_ff;
      ofs_x_in    = ofs_x_ff;
      ofs_y_in    = ofs_y_ff;
      tile_col_in = tile_col_ff;
      tile_row_in = tile_row_ff;

      if (advance) begin
         if (row_end) begin
            pix_col_in  = '0;
            ofs_x_in    = '0;
            tile_col_in = '0;
            if (col_end) begin
               pix_row_in  = '0;
               ofs_y_in    = '0;
               tile_row_in = '0;
            end else begin
               pix_row_in = pix_row_ff + POS_W'(1);
               if (tile_y_end) begin
                  ofs_y_in    = '0;
                  tile_row_in = tile_row_ff + IDX_W'(1);
               end else begin
                  ofs_y_in = ofs_y_ff + OFS_W'(1);
               end
            end
         end else begin
            pix_col_in = pix_col_ff + POS_W'(1);
            if (tile_x_end) begin
               ofs_x_in    = '0;
               tile_col_in = tile_col_ff + IDX_W'(1);
            end else begin
               ofs_x_in = ofs_x_ff + OFS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_col_ff  <= '0;
         pix_row_ff  <= '0;
         ofs_x_ff    <= '0;
         ofs_y_ff    <= '0;
         tile_col_ff <= '0;
         tile_row_ff <= '0;
      end else begin
         pix_col_ff  <= pix_col_in;
         pix_row_ff  <= pix_row_in;
         ofs_x_ff    <= ofs_x_in;
         ofs_y_ff    <= ofs_y_in;
         tile_col_ff <= tile_col_in;
         tile_row_ff <= tile_row_in;
      end
   end

   assign pos.sum_addr    = tile_col_ff[SUM_ADDR_W-1:0];
   assign pos.tile_column = tile_col_ff;
   assign pos.tile_row    = tile_row_ff;
   assign pos.first_pixel = (ofs_x_ff == '0) && (ofs_y_ff == '0);
   assign pos.tile_done   = tile_x_end && tile_y_end;
   assign pos.image_done  = row_end && col_end;
   assign pos.count       = pix_count[COUNT_W-1:0];

endmodule

>>> rtl/core/tac_divider.sv
// three-lane restoring divider, one quotient bit per cycle, saturated to 8 bits
module tac_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  tac_pkg::sum_word_type         dividend,
   input  logic [tac_pkg::COUNT_W-1:0]   divisor,
   output logic                          busy,
   output logic [2:0][tac_pkg::CHAN_W-1:0] avg
);
   import tac_pkg::*;

   logic                     busy_ff, busy_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [COUNT_W-1:0]       dsor_ff;
   logic [2:0][COUNT_W-1:0]  rem_ff, rem_in;
   logic [2:0][SUM_W-1:0]    quo_ff, quo_in;
   logic [2:0][COUNT_W:0]    trial;
   logic [2:0][SUM_W-1:0]    start_val;

   assign start_val[0] = dividend.red;
   assign start_val[1] = dividend.green;
   assign start_val[2] = dividend.blue;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      for (int lane = 0; lane < 3; lane++) begin
         trial[lane] = {rem_ff[lane], quo_ff[lane][SUM_W-1]};
      end
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         for (int lane = 0; lane < 3; lane++) begin
            rem_in[lane] = '0;
            quo_in[lane] = start_val[lane];
         end
      end else if (busy_ff) begin
         for (int lane = 0; lane < 3; lane++) begin
            if (trial[lane] >= {1'b0, dsor_ff}) begin
               rem_in[lane] = COUNT_W'(trial[lane] - {1'b0, dsor_ff});
               quo_in[lane] = {quo_ff[lane][SUM_W-2:0], 1'b1};
            end else begin
               rem_in[lane] = trial[lane][COUNT_W-1:0];
               quo_in[lane] = {quo_ff[lane][SUM_W-2:0], 1'b0};
            end
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dsor_ff <= divisor;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_comb begin
      for (int lane = 0; lane < 3; lane++) begin
         avg[lane] = (|quo_ff[lane][SUM_W-1:CHAN_W]) ? {CHAN_W{1'b1}}
                                                     : quo_ff[lane][CHAN_W-1:0];
      end
   end

   assign busy = busy_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (step_ff == STEP_W'(SUM_W - 1)) |=> !busy_ff)
      else $error("divider ran past its last step");

endmodule

>>> rtl/core/tile_average_colour.sv
// top level: tile average colour downsampler with band sum memory and divider
//
//  channel  dir  word fields (lsb first)                          handshake
//  req      in   red, green, blue                                 tvalid/tready
//  rsp      out  tile_column, tile_row, avg_red/green/blue; tlast tvalid/tready
//  csr      in   tile_size, image_width, image_height by index    we only
//
// each pixel is read from memory on accept, then added and written back in ST_ACCUM
// a pixel that closes a tile also waits for the 20 divider steps and the result load,
// plus any wait for the output register to free up
// reset is synchronous; sums need no clearing since a band's first row writes them
// a new pixel is taken while a finished result waits in the output register
module tile_average_colour (
   input  logic                             clock,
   input  logic                             reset,
   // red [7:0], green [15:8], blue [23:16]
   input  logic [tac_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tile_column [10:0], tile_row [21:11], avg_red [29:22], avg_green [37:30],
   // avg_blue [45:38], zero [47:46]
   output logic [tac_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_we,
   input  logic [tac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tac_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tac_pkg::*;

   state_type state_ff, state_in;
   cfg_type   cfg_ff;

   pos_info_type pos;
   sum_word_type rd_sum;
   sum_word_type new_sum;
   logic [2:0][CHAN_W-1:0] avg;
   logic div_busy;
   logic accept;
   logic accum;
   logic start_div;
   logic out_free;
   logic rsp_load;

   logic [CHAN_W-1:0] pix_r_ff, pix_g_ff, pix_b_ff;
   logic [IDX_W-1:0]  meta_col_ff, meta_row_ff;
   logic              meta_done_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_col_ff, rsp_row_ff;
   logic [CHAN_W-1:0] rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic              rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tile_size    <= TILE_SIZE_RESET;
         cfg_ff.image_width  <= IMAGE_WIDTH_RESET;
         cfg_ff.image_height <= IMAGE_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TILE_SIZE:    cfg_ff.tile_size    <= csr_wdata[TSIZE_W-1:0];
            CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata;
            CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      accum      = 1'b0;
      start_div  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            accum = 1'b1;
            if (pos.tile_done) begin
               start_div = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (!div_busy && out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      if (pos.first_pixel) begin
         new_sum.red   = SUM_W'(pix_r_ff);
         new_sum.green = SUM_W'(pix_g_ff);
         new_sum.blue  = SUM_W'(pix_b_ff);
      end else begin
         new_sum.red   = rd_sum.red   + SUM_W'(pix_r_ff);
         new_sum.green = rd_sum.green + SUM_W'(pix_g_ff);
         new_sum.blue  = rd_sum.blue  + SUM_W'(pix_b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_r_ff <= req_tdata[CHAN_W-1:0];
         pix_g_ff <= req_tdata[2*CHAN_W-1:CHAN_W];
         pix_b_ff <= req_tdata[3*CHAN_W-1:2*CHAN_W];
      end
      // tile indices must be caught before the tracker moves on
      if (start_div) begin
         meta_col_ff  <= pos.tile_column;
         meta_row_ff  <= pos.tile_row;
         meta_done_ff <= pos.image_done;
      end
   end

   tac_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .advance (accum),
      .pos     (pos)
   );

   tac_sum_ram u_sum_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (pos.sum_addr),
      .rd_data (rd_sum),
      .wr_en   (accum),
      .wr_addr (pos.sum_addr),
      .wr_data (new_sum)
   );

   tac_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (start_div),
      .dividend (new_sum),
      .divisor  (pos.count),
      .busy     (div_busy),
      .avg      (avg)
   );

   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_col_ff  <= meta_col_ff;
         rsp_row_ff  <= meta_row_ff;
         rsp_r_ff    <= avg[0];
         rsp_g_ff    <= avg[1];
         rsp_b_ff    <= avg[2];
         rsp_last_ff <= meta_done_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_b_ff, rsp_g_ff, rsp_r_ff, rsp_row_ff, rsp_col_ff};

   a_accept_to_accum: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_ACCUM))
      else $error("accepted word did not move to accumulate");

   a_load_after_div: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !div_busy && out_free)
      else $error("result loaded while divider busy or output full");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DIVIDE))
      else $error("result appeared without a finished division");

endmodule

>>> tb/tile_average_colour_test.sv
// self-checking testbench for the tile average colour downsampler
`timescale 1ns / 1ps

module tile_average_colour_test;
   import tac_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int SETTLE_CYCLES = 48;
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_PIXELS = 850;

   typedef struct {
      logic [IDX_W-1:0]  tile_column;
      logic [IDX_W-1:0]  tile_row;
      logic [CHAN_W-1:0] avg_red;
      logic [CHAN_W-1:0] avg_green;
      logic [CHAN_W-1:0] avg_blue;
      logic              image_done;
   } tile_average_type;

   class tile_average_predictor;
      logic [SUM_W-1:0]   sum_red   [MAX_TILES_ACROSS];
      logic [SUM_W-1:0]   sum_green [MAX_TILES_ACROSS];
      logic [SUM_W-1:0]   sum_blue  [MAX_TILES_ACROSS];
      logic [TSIZE_W-1:0] tile_size;
      logic [SIDE_W-1:0]  image_width;
      logic [SIDE_W-1:0]  image_height;
      logic [POS_W-1:0]   pixel_x, pixel_y;
      logic [OFS_W-1:0]   ofs_x, ofs_y;
      logic [IDX_W-1:0]   tile_x, tile_y;
      tile_average_type   expected_tiles [$];
      int                 errors;

      function new();
         tile_size    = TILE_SIZE_RESET;
         image_width  = IMAGE_WIDTH_RESET;
         image_height = IMAGE_HEIGHT_RESET;
         pixel_x = '0;
         pixel_y = '0;
         ofs_x   = '0;
         ofs_y   = '0;
         tile_x  = '0;
         tile_y  = '0;
         errors  = 0;
      endfunction

      function int pending();
         return expected_tiles.size();
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_TILE_SIZE:    tile_size    = value[TSIZE_W-1:0];
            CSR_IMAGE_WIDTH:  image_width  = value[SIDE_W-1:0];
            CSR_IMAGE_HEIGHT: image_height = value[SIDE_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [CHAN_W-1:0] channel_average(logic [SUM_W-1:0] sum, int unsigned pixels);
         int unsigned quotient;
         quotient = sum / pixels;
         return (quotient > 255) ? 8'hFF : quotient[CHAN_W-1:0];
      endfunction

      function void note_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                               logic [CHAN_W-1:0] b);
         int unsigned      side, w, h, pixels;
         logic             row_end, last_row, x_end, y_end;
         tile_average_type result;
         side = (tile_size < MIN_TILE) ? MIN_TILE :
                (tile_size > MAX_TILE) ? MAX_TILE : tile_size;
         w = (image_width == 0) ? 1 :
             (image_width > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : image_width;
         h = (image_height == 0) ? 1 :
             (image_height > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : image_height;
         row_end  = (pixel_x >= w - 1);
         last_row = (pixel_y >= h - 1);
         x_end    = row_end || (ofs_x >= side - 1);
         y_end    = last_row || (ofs_y >= side - 1);

         // first pixel of a tile starts its sums over
         if (ofs_x == 0 && ofs_y == 0) begin
            sum_red[tile_x]   = SUM_W'(r);
            sum_green[tile_x] = SUM_W'(g);
            sum_blue[tile_x]  = SUM_W'(b);
         end else begin
            sum_red[tile_x]   = sum_red[tile_x] + SUM_W'(r);
            sum_green[tile_x] = sum_green[tile_x] + SUM_W'(g);
            sum_blue[tile_x]  = sum_blue[tile_x] + SUM_W'(b);
         end

         if (x_end && y_end) begin
            pixels = (ofs_x + 1) * (ofs_y + 1);
            result.tile_column = tile_x;
            result.tile_row    = tile_y;
            result.avg_red     = channel_average(sum_red[tile_x], pixels);
            result.avg_green   = channel_average(sum_green[tile_x], pixels);
            result.avg_blue    = channel_average(sum_blue[tile_x], pixels);
            result.image_done  = row_end && last_row;
            expected_tiles.push_back(result);
         end

         if (row_end) begin
            pixel_x = '0;
            ofs_x   = '0;
            tile_x  = '0;
            if (last_row) begin
               pixel_y = '0;
               ofs_y   = '0;
               tile_y  = '0;
            end else begin
               pixel_y = pixel_y + 1'b1;
               if (y_end) begin
                  ofs_y  = '0;
                  tile_y = tile_y + 1'b1;
               end else begin
                  ofs_y = ofs_y + 1'b1;
               end
            end
         end else begin
            pixel_x = pixel_x + 1'b1;
            if (x_end) begin
               ofs_x  = '0;
               tile_x = tile_x + 1'b1;
            end else begin
               ofs_x = ofs_x + 1'b1;
            end
         end
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_tile(logic [RSP_DATA_W-1:0] data, logic last);
         tile_average_type want;
         if (expected_tiles.size() == 0) begin
            $display("%0t: unexpected tile word, expected none, actual %h last %b",
                     $time, data, last);
            errors++;
            return;
         end
         want = expected_tiles.pop_front();
         compare("tile_column", want.tile_column, data[IDX_W-1:0]);
         compare("tile_row", want.tile_row, data[IDX_W +: IDX_W]);
         compare("avg_red", want.avg_red, data[2*IDX_W +: CHAN_W]);
         compare("avg_green", want.avg_green, data[2*IDX_W+CHAN_W +: CHAN_W]);
         compare("avg_blue", want.avg_blue, data[2*IDX_W+2*CHAN_W +: CHAN_W]);
         compare("image_done", want.image_done, last);
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int send_idle_pct = 22;
   int recv_idle_pct = 68;
   bit hold_requested = 1'b0;
   tile_average_predictor tiles = new();

   tile_average_colour u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      do @(posedge clock); while (!req_tready);
      tiles.note_pixel(r, g, b);
   endtask

   task automatic send_random_pixel();
      send_pixel(CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                 CHAN_W'($urandom_range(0, 255)));
   endtask

   task automatic send_image(input int unsigned cols, rows);
      repeat (cols * rows) send_random_pixel();
   endtask

   // all tiles back, then time for a pixel that closes nothing to drain
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (tiles.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      tiles.write_register(index, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] t, w, h);
      write_csr(CSR_TILE_SIZE, t);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
   endtask

   // start a huge image, then shrink it so the next pixel closes tile and image
   task automatic send_truncated(input logic [CSR_DATA_W-1:0] t, w, h,
                                 input logic [CSR_IDX_W-1:0] shrink_index,
                                 input logic [CSR_DATA_W-1:0] shrink_value);
      configure(t, w, h);
      repeat (130) send_random_pixel();
      wait_for_idle();
      write_csr(shrink_index, shrink_value);
      send_random_pixel();
   endtask

   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            tiles.check_tile(rsp_tdata, rsp_tlast);
         end
         if (hold_requested) begin
            hold_requested = 1'b0;
            hold_left      = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin : stall_watch
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stalled = 0;
         end else begin
            stalled++;
         end
      end
      $display("tile_average_colour_test failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned           phase, sent, phase_sent, pick, cols, rows;
      logic [CSR_DATA_W-1:0] t, w, h;
      bit                    held;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 3x3 image, tile size 0 acts as 2: full, right-cut, bottom-cut and corner tiles
      configure(0, 3, 3);
      write_csr(CSR_UNMAPPED, '1);
      for (int i = 0; i < 9; i++) begin
         send_pixel((i % 2) ? 8'hFF : 8'h00, 8'(i * 31), 8'hFF - 8'(i * 7));
      end

      // width 0 acts as 1, tile size 1 acts as 2; floor of odd sums
      wait_for_idle();
      configure(1, 0, 2);
      send_pixel(8'hFF, 8'h00, 8'h01);
      send_pixel(8'hFE, 8'h01, 8'h00);

      // narrowing mid band leaves more pixels in the sum than the count: saturates
      wait_for_idle();
      configure(4, 8, 4);
      repeat (9) send_pixel(8'hFF, 8'h00, 8'hFF);
      wait_for_idle();
      write_csr(CSR_IMAGE_WIDTH, 2);
      repeat (5) send_pixel(8'hFF, 8'h80, 8'hFF);

      phase = 0;
      sent  = 0;
      held  = 1'b0;
      while (sent < RANDOM_PIXELS) begin
         wait_for_idle();
         if (sent >= 2 * RANDOM_PIXELS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (sent >= RANDOM_PIXELS / 3) begin
            send_idle_pct = 68;
            recv_idle_pct = 22;
         end
         if (send_idle_pct == 0 && !held) begin
            // long receiver back-off while pixels keep coming
            hold_requested = 1'b1;
            held           = 1'b1;
         end
         if (phase == 2) begin
            send_truncated(127, 8191, 1, CSR_IMAGE_WIDTH, 3);
            sent += 131;
         end else if (phase == 5) begin
            send_truncated(64, 1, 8191, CSR_IMAGE_HEIGHT, 1);
            sent += 131;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               t = CSR_DATA_W'($urandom_range(0, 9));
               w = CSR_DATA_W'($urandom_range(0, 24));
               h = CSR_DATA_W'($urandom_range(0, 12));
            end else begin
               t = CSR_DATA_W'($urandom_range(60, 127));
               w = CSR_DATA_W'($urandom_range(1, 90));
               h = CSR_DATA_W'($urandom_range(1, 4));
            end
            configure(t, w, h);
            cols = (w == 0) ? 1 : w;
            rows = (h == 0) ? 1 : h;
            phase_sent = 0;
            while (phase_sent < 60) begin
               send_image(cols, rows);
               phase_sent += cols * rows;
            end
            sent += phase_sent;
         end
         phase++;
      end

      wait_for_idle();
      if (tiles.errors == 0 && tiles.pending() == 0) begin
         $display("tile_average_colour_test passed");
      end else begin
         $display("tile_average_colour_test failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/tac_pkg.sv
rtl/core/tac_sum_ram.sv
rtl/core/tac_tracker.sv
rtl/core/tac_divider.sv
rtl/core/tile_average_colour.sv
tb/tile_average_colour_test.sv
